/* design/assert_macros.svh */
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// expr must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");
// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/b64_pkg.sv */
`default_nettype none

package b64_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3D;   // '='
    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;
    localparam logic       MODE_ENC   = 1'b0;
    localparam logic       MODE_DEC   = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_req;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
        logic       error;
    } t_out_word;

    typedef struct packed {
        logic [23:0] group_bits;
        logic [1:0]  group_pos;
        logic        pad_seen;
        logic        error_flag;
    } t_state;

    // up to four words produced by one accepted item; words[0] goes out first
    typedef struct packed {
        t_out_word [3:0] words;
        logic [2:0]      num;
    } t_burst;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)      c = {2'b00, v} + 8'd65;
        else if (v < 6'd52) c = {2'b00, v} + 8'd71;
        else if (v < 6'd62) c = {2'b00, v} - 8'd4;
        else if (v == 6'd62) c = 8'h2B;
        else                c = 8'h2F;
        return c;
    endfunction

    // character to sextet, pad code or bad code
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [6:0] s;
        if (c inside {[8'h41:8'h5A]})      s = 7'(c - 8'h41);
        else if (c inside {[8'h61:8'h7A]}) s = 7'(c - 8'h47);
        else if (c inside {[8'h30:8'h39]}) s = 7'(c + 8'd4);
        else if (c == 8'h2B)               s = 7'd62;
        else if (c == 8'h2F)               s = 7'd63;
        else if (c == PAD_CHAR)            s = SEXTET_PAD;
        else                               s = SEXTET_BAD;
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/b64_step.sv */
`default_nettype none

// Next group state and output burst for one accepted word.
module b64_step import b64_pkg::*; (
    input  wire logic     i_mode,
    input  wire t_state   i_state,
    input  wire t_in_word i_in,
    output t_state        o_state,
    output t_burst        o_burst
);

    logic [23:0] enc_bits;
    logic [2:0]  enc_n;
    logic [23:0] enc_v;
    logic [7:0]  enc_ch [4];

    logic [6:0]  sx;
    logic        is_pad;
    logic        dec_err;
    logic        dec_pad;
    logic [23:0] dec_bits;
    logic [2:0]  dec_nb;
    logic [7:0]  dec_b [3];

    // encode datapath
    always_comb begin
        enc_bits = {i_state.group_bits[15:0], i_in.data_byte};
        enc_n    = {1'b0, i_state.group_pos} + 3'd1;
        case (enc_n)
            3'd1:    enc_v = {enc_bits[7:0], 16'h0000};
            3'd2:    enc_v = {enc_bits[15:0], 8'h00};
            default: enc_v = enc_bits;
        endcase
        enc_ch[0] = enc_char(enc_v[23:18]);
        enc_ch[1] = enc_char(enc_v[17:12]);
        enc_ch[2] = (enc_n >= 3'd2) ? enc_char(enc_v[11:6]) : PAD_CHAR;
        enc_ch[3] = (enc_n >= 3'd3) ? enc_char(enc_v[5:0]) : PAD_CHAR;
    end

    // decode datapath
    always_comb begin
        sx       = dec_sextet(i_in.data_byte);
        is_pad   = (sx == SEXTET_PAD);
        dec_err  = i_state.error_flag | (sx == SEXTET_BAD)
                 | (is_pad & (i_state.group_pos < 2'd2));
        dec_pad  = i_state.pad_seen | (is_pad & (i_state.group_pos == 2'd2));
        dec_bits = {i_state.group_bits[17:0], (sx[6] ? 6'd0 : sx[5:0])};
        dec_nb   = i_state.pad_seen ? 3'd1 : (is_pad ? 3'd2 : 3'd3);
        dec_b[0] = dec_bits[23:16];
        dec_b[1] = dec_bits[15:8];
        dec_b[2] = dec_bits[7:0];
    end

    // state update and burst assembly
    always_comb begin
        o_state = i_state;
        o_burst = '0;
        if (i_mode == MODE_ENC) begin
            if (enc_n < 3'd3 && !i_in.final_req) begin
                o_state.group_bits = enc_bits;
                o_state.group_pos  = enc_n[1:0];
            end else begin
                for (int i = 0; i < 4; i++) begin
                    o_burst.words[i].out_byte    = enc_ch[i];
                    o_burst.words[i].run_last    = (i == 3);
                    o_burst.words[i].message_end = (i == 3) && i_in.final_req;
                    o_burst.words[i].error       = 1'b0;
                end
                o_burst.num = 3'd4;
                o_state     = '0;
            end
        end else begin
            o_state.group_bits = dec_bits;
            o_state.pad_seen   = dec_pad;
            o_state.error_flag = dec_err;
            if (i_state.group_pos < 2'd3) begin
                o_state.group_pos = i_state.group_pos + 2'd1;
                if (i_in.final_req) o_state.error_flag = 1'b1;
            end else begin
                if (!dec_err) begin
                    for (int i = 0; i < 3; i++) begin
                        if (3'(i) < dec_nb) begin
                            o_burst.words[i].out_byte    = dec_b[i];
                            o_burst.words[i].run_last    = (3'(i + 1) == dec_nb);
                            o_burst.words[i].message_end = (3'(i + 1) == dec_nb)
                                                         && i_in.final_req;
                        end
                    end
                    o_burst.num = dec_nb;
                end
                o_state.group_bits = '0;
                o_state.group_pos  = '0;
                o_state.pad_seen   = 1'b0;
            end
            if (i_in.final_req) begin
                // sticky error reported as one closing word
                if (o_state.error_flag) begin
                    o_burst       = '0;
                    o_burst.words[0].run_last    = 1'b1;
                    o_burst.words[0].message_end = 1'b1;
                    o_burst.words[0].error       = 1'b1;
                    o_burst.num   = 3'd1;
                end
                o_state = '0;
            end
        end
    end

endmodule

`default_nettype wire

/* design/base64_codec.sv */
`default_nettype none
// Latency: first result word is valid the cycle after its input word is accepted.
// Throughput: output queue drains one word per cycle when the receiver is ready; an
// input word is taken when the queue is empty or its last word leaves that cycle,
// so a new input word waits until the words owed for the one before have drained.
// Reset (synchronous, active low) clears mode to encode, group state and queue.
`include "assert_macros.svh"

module base64_codec import b64_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_mode_we,
    input  wire logic      i_mode_wdata,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out
);

    logic            r_mode;
    t_state          r_state;
    t_state          n_state;
    t_burst          n_burst;
    t_out_word [3:0] r_q;
    logic [2:0]      r_cnt;
    logic            in_fire;
    logic            out_fire;

    b64_step u_step (
        .i_mode  (r_mode),
        .i_state (r_state),
        .i_in    (i_in),
        .o_state (n_state),
        .o_burst (n_burst)
    );

    // handshake
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out       = r_q[0];
    assign out_fire    = o_out_valid & i_out_ready;
    assign o_in_ready  = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && i_out_ready);
    assign in_fire     = i_in_valid & o_in_ready;

    // mode register and group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_ENC;
            r_state <= '0;
        end else if (i_mode_we) begin
            r_mode  <= i_mode_wdata;
            r_state <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // output queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_fire) begin
            r_cnt <= n_burst.num;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // output queue payload, shifts toward slot 0
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_q <= n_burst.words;
        end else if (out_fire) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
            r_q[2] <= r_q[3];
        end
    end

    `ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt <= 3'd4)
    `ASSERT_IMPLY(a_err_closes, i_clk, i_rst_n, o_out_valid && o_out.error,
                  o_out.run_last && o_out.message_end && (o_out.out_byte == 8'h00))
    `ASSERT_IMPLY(a_err_decode, i_clk, i_rst_n, o_out_valid && o_out.error,
                  r_mode == MODE_DEC)
    `ASSERT_IMPLY(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_out.message_end,
                  o_out.run_last && (r_cnt == 3'd1))

endmodule

`default_nettype wire

/* test/tb_base64_codec.sv */
`default_nettype none

module tb_base64_codec import b64_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 400;
    localparam int PHASE_ITEMS = 28;
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // receiver stall patterns
    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_style;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      mode_we = 1'b0;
    logic      mode_wdata = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    // words waiting to be sent, and words the block owes us
    t_in_word  queued_in_words[$];
    t_out_word due_out_words[$];

    // codec state as the checker sees it
    logic        cfg_mode = MODE_ENC;
    logic [23:0] grp_bits = '0;
    logic [1:0]  grp_pos = '0;
    logic        pad_hit = 1'b0;
    logic        err_sticky = 1'b0;

    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        send_gap = 0;
    int        send_burst = 1;
    int        rx_left = 0;
    t_rx_style rx_style = RX_OPEN;

    base64_codec u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode_we    (mode_we),
        .i_mode_wdata (mode_wdata),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in         (in_word),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out        (out_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // alphabet lookups, both directions
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        return ALPHABET[8*(63 - v) +: 8];
    endfunction

    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [6:0] s;
        s = SEXTET_BAD;
        if (c == PAD_CHAR) s = SEXTET_PAD;
        for (int k = 0; k < 64; k++) begin
            if (sextet_char(6'(k)) == c) s = 7'(k);
        end
        return s;
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_pos = '0;
        pad_hit = 1'b0;
        err_sticky = 1'b0;
    endtask

    task automatic owe_word(input logic [7:0] b, input logic rl, input logic me,
                            input logic er);
        t_out_word w;
        w.out_byte = b;
        w.run_last = rl;
        w.message_end = me;
        w.error = er;
        due_out_words.push_back(w);
    endtask

    // encode: four characters per full group or on the final byte
    task automatic predict_encode(input logic [7:0] b, input logic fin);
        int n;
        logic [23:0] v;
        logic [7:0] ch [4];
        grp_bits = {grp_bits[15:0], b};
        n = grp_pos + 1;
        if (n < 3 && !fin) begin
            grp_pos = 2'(n);
            return;
        end
        v = grp_bits << (8 * (3 - n));
        ch[0] = sextet_char(v[23:18]);
        ch[1] = sextet_char(v[17:12]);
        ch[2] = (n >= 2) ? sextet_char(v[11:6]) : PAD_CHAR;
        ch[3] = (n >= 3) ? sextet_char(v[5:0]) : PAD_CHAR;
        for (int i = 0; i < 4; i++) owe_word(ch[i], i == 3, (i == 3) && fin, 1'b0);
        clear_group();
    endtask

    // decode: bytes on the fourth character, error word at a message end with an error
    task automatic predict_decode(input logic [7:0] c, input logic fin);
        logic [6:0] s;
        logic [1:0] pos;
        int nbytes;
        s = char_sextet(c);
        pos = grp_pos;
        if (s == SEXTET_BAD) err_sticky = 1'b1;
        if (s == SEXTET_PAD && pos < 2) err_sticky = 1'b1;
        if (s == SEXTET_PAD && pos == 2) pad_hit = 1'b1;
        grp_bits = {grp_bits[17:0], (s < SEXTET_PAD) ? s[5:0] : 6'd0};
        if (pos < 3) begin
            grp_pos = pos + 2'd1;
            if (fin) err_sticky = 1'b1;
        end else begin
            nbytes = pad_hit ? 1 : ((s == SEXTET_PAD) ? 2 : 3);
            if (!err_sticky) begin
                for (int i = 0; i < nbytes; i++) begin
                    owe_word(grp_bits[16 - 8*i +: 8], i + 1 == nbytes,
                             (i + 1 == nbytes) && fin, 1'b0);
                end
            end
            grp_bits = '0;
            grp_pos = '0;
            pad_hit = 1'b0;
        end
        if (fin) begin
            if (err_sticky) owe_word(8'h00, 1'b1, 1'b1, 1'b1);
            clear_group();
        end
    endtask

    task automatic check_field(input string label, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // sender: bursts of words with random gaps
    always @(posedge i_clk) begin : sender
        logic next_valid;
        t_in_word next_word;
        next_valid = in_valid;
        next_word = in_word;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!in_valid || in_ready) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (queued_in_words.size() > 0) begin
                next_word = queued_in_words.pop_front();
                next_valid = 1'b1;
                if (send_burst > 1) begin
                    send_burst--;
                end else begin
                    send_burst = $urandom_range(1, 12);
                    send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        in_valid <= next_valid;
        in_word <= next_word;
    end

    // receiver: switches between stall patterns
    always @(posedge i_clk) begin : receiver
        logic next_ready;
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left = $urandom_range(1, 24);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_OPEN:   next_ready = 1'b1;
            RX_COIN:   next_ready = 1'($urandom_range(0, 1));
            RX_SPARSE: next_ready = (rx_left % 4 == 0);
            default:   next_ready = 1'b0;
        endcase
        if (!i_rst_n) next_ready = 1'b0;
        out_ready <= next_ready;
    end

    // monitor: check results, predict on accepted words, watchdog
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (due_out_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $time, out_word);
                    mismatch_count++;
                end else begin
                    want = due_out_words.pop_front();
                    check_field("out_byte", want.out_byte, out_word.out_byte);
                    check_field("run_last", want.run_last, out_word.run_last);
                    check_field("message_end", want.message_end, out_word.message_end);
                    check_field("error", want.error, out_word.error);
                end
            end
            if (in_valid && in_ready) begin
                if (cfg_mode == MODE_ENC) predict_encode(in_word.data_byte, in_word.final_req);
                else predict_decode(in_word.data_byte, in_word.final_req);
            end
            if ((out_valid && out_ready) || (in_valid && in_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_base64_codec: FAIL");
                $finish;
            end
        end
    end

    // stimulus helpers
    task automatic queue_word(input logic [7:0] b, input logic fin);
        t_in_word w;
        w.data_byte = b;
        w.final_req = fin;
        queued_in_words.push_back(w);
    endtask

    task automatic queue_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) queue_word(s[i], fin && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (queued_in_words.size() != 0 || in_valid || due_out_words.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // mode write only once the block has gone quiet
    task automatic write_mode(input logic m);
        wait_idle();
        repeat (4) @(posedge i_clk);
        mode_wdata <= m;
        mode_we <= 1'b1;
        cfg_mode = m;
        clear_group();
        @(posedge i_clk);
        mode_we <= 1'b0;
    endtask

    // well-formed base64 text of len random bytes
    task automatic queue_encoded_message(input int len);
        logic [23:0] v;
        int rem;
        bit last;
        for (int g = 0; g < len; g += 3) begin
            rem = len - g;
            v = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
            if (rem < 3) v[7:0] = 8'h00;
            if (rem < 2) v[15:8] = 8'h00;
            last = (rem <= 3);
            queue_word(sextet_char(v[23:18]), 1'b0);
            queue_word(sextet_char(v[17:12]), 1'b0);
            queue_word((rem >= 2) ? sextet_char(v[11:6]) : PAD_CHAR, 1'b0);
            queue_word((rem >= 3) ? sextet_char(v[5:0]) : PAD_CHAR, last);
        end
    endtask

    // mostly alphabet, some pads, some arbitrary bytes
    task automatic queue_noise_message(input int len);
        int pick;
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) c = sextet_char(6'($urandom_range(0, 63)));
            else if (pick < 8) c = PAD_CHAR;
            else c = 8'($urandom_range(0, 255));
            queue_word(c, i == len - 1);
        end
    endtask

    task automatic run_random_phase(input logic m, input bit hold_once);
        int target;
        int len;
        write_mode(m);
        target = queued_in_words.size() + PHASE_ITEMS;
        while (queued_in_words.size() < target) begin
            if (m == MODE_ENC) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
                                                  : $urandom_range(1, 8);
                for (int i = 0; i < len; i++) queue_word(8'($urandom_range(0, 255)),
                                                         i == len - 1);
            end else if ($urandom_range(0, 4) != 0) begin
                queue_encoded_message($urandom_range(1, 9));
            end else begin
                queue_noise_message($urandom_range(1, 10));
            end
            // sender holds off mid-message until the block has caught up
            if (hold_once) begin
                hold_once = 0;
                queue_word(8'($urandom_range(0, 255)), 1'b0);
                wait_idle();
                target = PHASE_ITEMS / 2;
            end
        end
        // sometimes leave a message open across the next mode write
        repeat ($urandom_range(0, 3)) queue_word(8'($urandom_range(0, 255)), 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // encode: full group, one-byte tail, two-byte tail
        write_mode(MODE_ENC);
        queue_word(8'hFB, 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word(8'hBF, 1'b0);
        queue_word(8'h00, 1'b1);
        queue_word(8'h80, 1'b0);
        queue_word(8'h7F, 1'b1);

        // decode: third-place pad with a trailing char, fourth-place pad,
        // misplaced pad and bad chars, then a short message
        write_mode(MODE_DEC);
        queue_text("AB=z", 1'b0);
        queue_text("TWE=", 1'b1);
        queue_text("A=AA", 1'b0);
        queue_word(8'h00, 1'b0);
        queue_word("b", 1'b0);
        queue_word(8'hFF, 1'b0);
        queue_word("d", 1'b1);
        queue_text("+/09", 1'b0);
        queue_text("a", 1'b1);
        queue_text("TW", 1'b0);

        run_random_phase(MODE_DEC, 0);
        run_random_phase(MODE_ENC, 1);
        run_random_phase(MODE_DEC, 0);
        run_random_phase(MODE_DEC, 0);
        run_random_phase(MODE_ENC, 0);

        wait_idle();
        repeat (12) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_base64_codec: PASS");
        end else begin
            $display("tb_base64_codec: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+design
design/b64_pkg.sv
design/b64_step.sv
design/base64_codec.sv
test/tb_base64_codec.sv
